// File: src/dasp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dasp_pkg;

  // Field widths of the item and result words.
  localparam int RAW_W     = 13;
  localparam int SMOOTH_W  = 12;
  localparam int VALUE_W   = 16;
  localparam int MODE_W    = 2;
  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_PARAM  = 2'd1;
  localparam logic [OP_W-1:0] OP_TRACK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PARAM     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_THRESHOLD = 1'b1;

  localparam logic [SMOOTH_W-1:0] THRESHOLD_RESET = 12'd200;

  // Pickup mode codes as they appear on the result word.
  localparam logic [MODE_W-1:0] MODE_RESET  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRACK  = 2'd2;

  typedef enum logic [2:0] {
    PK_RESET  = 3'b001,
    PK_LOCKED = 3'b010,
    PK_TRACK  = 3'b100
  } pickup_state_t;

  // Item held in the compute stage.
  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [RAW_W-1:0]          raw;
    logic [IDX_W-1:0]          idx;
    logic signed [VALUE_W-1:0] value;
    logic                      ch;
  } item_t;

  // Result word as it waits in the output buffer.
  typedef struct packed {
    logic                      ch;
    logic [SMOOTH_W-1:0]       smoothed;
    logic signed [VALUE_W-1:0] active_value;
    logic [MODE_W-1:0]         mode;
  } out_word_t;

  function automatic logic [MODE_W-1:0] mode_code(pickup_state_t s);
    logic [MODE_W-1:0] code;
    case (s)
      PK_LOCKED: code = MODE_LOCKED;
      PK_TRACK:  code = MODE_TRACK;
      default:   code = MODE_RESET;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: src/dasp_filter.sv
`timescale 1ns / 1ps
`default_nettype none

module dasp_filter #(
  parameter int FILTER_SHIFT = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_ch,
  input  logic                           upd_en,
  input  logic                           upd_ch,
  input  logic [dasp_pkg::RAW_W-1:0]     upd_raw,
  output logic [dasp_pkg::SMOOTH_W-1:0]  smoothed
);
  import dasp_pkg::*;

  localparam int ACC_W = RAW_W + FILTER_SHIFT;

  logic [ACC_W-1:0]        acc_mem [2];
  logic [1:0]              acc_ok;
  logic [ACC_W-1:0]        acc_rd;
  logic                    acc_rd_ok;
  logic [ACC_W-1:0]        acc_cur;
  logic [RAW_W-1:0]        inv;
  logic [ACC_W-1:0]        target;
  logic signed [ACC_W:0]   diff;
  logic signed [ACC_W:0]   step;
  logic signed [ACC_W:0]   sum;
  logic [ACC_W-1:0]        acc_new;

  // Accumulator memory: read every cycle at the toggle's channel, written back
  // in the following cycle. An entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (upd_en) begin
      acc_mem[upd_ch] <= acc_new;
    end
    acc_rd    <= acc_mem[rd_ch];
    acc_rd_ok <= acc_ok[rd_ch];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_ok <= '0;
    end else if (upd_en) begin
      acc_ok[upd_ch] <= 1'b1;
    end
  end

  // One-pole update with a floor shift of the signed error.
  always_comb begin
    acc_cur = acc_rd_ok ? acc_rd : '0;
    inv     = ~upd_raw;
    target  = {inv, {FILTER_SHIFT{1'b0}}};
    diff    = $signed({1'b0, target}) - $signed({1'b0, acc_cur});
    step    = diff >>> FILTER_SHIFT;
    sum     = $signed({1'b0, acc_cur}) + step;
    acc_new = sum[ACC_W] ? '0 : sum[ACC_W-1:0];
  end

  assign smoothed = acc_new[ACC_W-1 -: SMOOTH_W];

  // Channels alternate, so a write-back never meets a read of the same entry.
  a_no_acc_collision: assert property (@(posedge clk) disable iff (rst)
    upd_en |-> rd_ch != upd_ch)
    else $error("accumulator read and write-back hit the same channel");

endmodule

`default_nettype wire

// File: src/dasp_param.sv
`timescale 1ns / 1ps
`default_nettype none

module dasp_param #(
  parameter int PARAM_COUNT = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dasp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dasp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 s1_valid,
  input  dasp_pkg::item_t                      s1,
  input  logic [dasp_pkg::SMOOTH_W-1:0]        smoothed,
  output logic signed [dasp_pkg::VALUE_W-1:0]  active_value,
  output logic [dasp_pkg::MODE_W-1:0]          mode
);
  import dasp_pkg::*;

  localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

  logic [IDX_W-1:0]       active_param;
  logic [SMOOTH_W-1:0]    threshold;
  logic [SMOOTH_W-1:0]    pk_ref;
  pickup_state_t          pk_state;
  pickup_state_t          pk_next;
  logic [VALUE_W-1:0]     tbl [PARAM_COUNT];
  logic [PARAM_COUNT-1:0] slot_ok;
  logic [AW-1:0]          act_addr;
  logic [IDX_W-1:0]       new_act;
  logic                   new_act_ok;
  logic                   sample_hi;
  logic                   idx_ok;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_W-1:0]     wr_data;
  logic [SMOOTH_W-1:0]    diff;
  logic [VALUE_W-1:0]     rd_mem;
  logic                   rd_ok;
  logic                   rd_fwd;
  logic [VALUE_W-1:0]     rd_fwd_data;
  logic [VALUE_W-1:0]     rd_value;

  assign act_addr   = AW'(active_param);
  assign new_act    = cfg_data[IDX_W-1:0];
  assign new_act_ok = 32'(new_act) < PARAM_COUNT;
  assign sample_hi  = s1_valid && (s1.op == OP_SAMPLE) && s1.ch;
  assign idx_ok     = 32'(s1.idx) < PARAM_COUNT;

  // Table write: an explicit parameter write or a tracking update.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = act_addr;
    wr_data = {{(VALUE_W-SMOOTH_W){1'b0}}, smoothed};
    if (s1_valid && (s1.op == OP_PARAM) && idx_ok) begin
      wr_en   = 1'b1;
      wr_addr = AW'(s1.idx);
      wr_data = s1.value;
    end else if (sample_hi && (pk_state == PK_TRACK)) begin
      wr_en = 1'b1;
    end
  end

  // Table memory with its registered read port on the active slot.
  // A write landing at the same edge is forwarded into the read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= wr_data;
    end
    rd_mem      <= tbl[act_addr];
    rd_ok       <= slot_ok[act_addr];
    rd_fwd      <= wr_en && (wr_addr == act_addr);
    rd_fwd_data <= wr_data;
  end

  // Valid bits stand in for clearing the table at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ok <= '0;
    end else if (wr_en) begin
      slot_ok[wr_addr] <= 1'b1;
    end
  end

  assign rd_value = rd_fwd ? rd_fwd_data : (rd_ok ? rd_mem : '0);

  // The active slot after this item, including its own write.
  assign active_value = $signed((wr_en && (wr_addr == act_addr)) ? wr_data : rd_value);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_param <= '0;
      threshold    <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_PARAM: begin
          if (new_act_ok) begin
            active_param <= new_act;
          end
        end
        REG_UNLOCK_THRESHOLD: begin
          threshold <= cfg_data[SMOOTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign diff = (smoothed >= pk_ref) ? smoothed - pk_ref : pk_ref - smoothed;

  // Soft-takeover pickup, advanced by channel one samples and forced to tracking by a track op.
  always_comb begin
    pk_next = pk_state;
    if (s1_valid && (s1.op == OP_TRACK)) begin
      pk_next = PK_TRACK;
    end else if (sample_hi) begin
      unique case (pk_state)
        PK_RESET:  pk_next = PK_LOCKED;
        PK_LOCKED: pk_next = (diff > threshold) ? PK_TRACK : PK_LOCKED;
        PK_TRACK:  pk_next = PK_TRACK;
        default:   pk_next = PK_RESET;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_state <= PK_RESET;
      pk_ref   <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_ACTIVE_PARAM) && new_act_ok
          && (new_act != active_param)) begin
        pk_state <= PK_RESET;
      end else begin
        pk_state <= pk_next;
      end
      if (sample_hi && (pk_state == PK_RESET)) begin
        pk_ref <= smoothed;
      end
    end
  end

  assign mode = mode_code(pk_next);

  // Only a configuration write ever takes the pickup out of tracking.
  a_track_holds: assert property (@(posedge clk) disable iff (rst)
    (pk_state == PK_TRACK) && !cfg_we |=> pk_state == PK_TRACK)
    else $error("pickup left tracking without a configuration write");

endmodule

`default_nettype wire

// File: src/dasp_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module dasp_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dasp_pkg::out_word_t   push_word,
  input  logic                  pop,
  output dasp_pkg::out_word_t   head_word,
  output logic                  not_empty,
  output logic [1:0]            count
);
  import dasp_pkg::*;

  localparam int DEPTH = 3;

  out_word_t  buf_mem [DEPTH];
  logic [1:0] head;
  logic [1:0] tail;

  // Three-word queue: one word in flight plus room for the receiver to stall.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[tail] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == 2'(DEPTH - 1)) ? '0 : tail + 2'd1;
      end
      if (pop) begin
        head <= (head == 2'(DEPTH - 1)) ? '0 : head + 2'd1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign not_empty = count != 2'd0;
  assign head_word = buf_mem[head];

endmodule

`default_nettype wire

// File: src/dual_adc_smoother_with_param_pickup.sv
// Two-channel converter smoother with soft-takeover parameter pickup.
// Input channel (in_valid/in_ready): one word per op. A sample word is
// inverted and filtered on the channel chosen by an internal toggle that
// starts at channel zero; channel one also drives the pickup into the
// parameter table. Other ops write a parameter slot or force tracking; code 3 does nothing.
// Output channel (out_valid/out_ready): exactly one result word per input
// word, in order. Configuration (cfg_valid/cfg_ready, always ready): index 0
// selects the active slot, index 1 sets the unlock threshold; write only
// while no word is in flight.
// The accepting edge reads the accumulator and table memories; the next edge
// writes back and enqueues the result, which raises out_valid. Throughput is one
// word per clock while in_ready is high, bounded by the single read-modify-write
// pass through the accumulator memory.
// A three-word output queue absorbs receiver stalls; in_ready drops once it
// and the compute stage together hold three words.
// Reset (synchronous) clears the toggle, filters, pickup and the table at
// once through per-entry valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module dual_adc_smoother_with_param_pickup #(
  parameter int PARAM_COUNT  = 8,
  parameter int FILTER_SHIFT = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dasp_pkg::OP_W-1:0]            op,
  input  logic [dasp_pkg::RAW_W-1:0]           raw_sample,
  input  logic [dasp_pkg::IDX_W-1:0]           param_index,
  input  logic signed [dasp_pkg::VALUE_W-1:0]  param_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 sample_channel,
  output logic [dasp_pkg::SMOOTH_W-1:0]        smoothed_value,
  output logic signed [dasp_pkg::VALUE_W-1:0]  active_value,
  output logic [dasp_pkg::MODE_W-1:0]          pickup_mode,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dasp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dasp_pkg::CFG_W-1:0]           cfg_data
);
  import dasp_pkg::*;

  logic                        in_fire;
  logic                        out_fire;
  logic                        toggle;
  logic                        s1_valid;
  item_t                       s1;
  logic [SMOOTH_W-1:0]         smoothed;
  logic signed [VALUE_W-1:0]   act_val;
  logic [MODE_W-1:0]           mode;
  logic                        is_sample;
  out_word_t                   res_word;
  out_word_t                   head_word;
  logic [1:0]                  out_cnt;
  logic [2:0]                  occupancy;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign occupancy = {1'b0, out_cnt} + 3'(s1_valid);
  assign in_ready  = occupancy < 3'd3;

  // Compute stage register and the channel toggle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      toggle   <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      if (in_fire && (op == OP_SAMPLE)) begin
        toggle <= ~toggle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= '{op: op, raw: raw_sample, idx: param_index, value: param_value, ch: toggle};
    end
  end

  assign is_sample = s1.op == OP_SAMPLE;

  dasp_filter #(
    .FILTER_SHIFT (FILTER_SHIFT)
  ) u_filter (
    .clk      (clk),
    .rst      (rst),
    .rd_ch    (toggle),
    .upd_en   (s1_valid && is_sample),
    .upd_ch   (s1.ch),
    .upd_raw  (s1.raw),
    .smoothed (smoothed)
  );

  dasp_param #(
    .PARAM_COUNT (PARAM_COUNT)
  ) u_param (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .smoothed     (smoothed),
    .active_value (act_val),
    .mode         (mode)
  );

  // Result word; channel and smoothed value only mean something for samples.
  always_comb begin
    res_word.ch           = is_sample ? s1.ch : 1'b0;
    res_word.smoothed     = is_sample ? smoothed : '0;
    res_word.active_value = act_val;
    res_word.mode         = mode;
  end

  dasp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_word (res_word),
    .pop       (out_fire),
    .head_word (head_word),
    .not_empty (out_valid),
    .count     (out_cnt)
  );

  assign sample_channel = head_word.ch;
  assign smoothed_value = head_word.smoothed;
  assign active_value   = head_word.active_value;
  assign pickup_mode    = head_word.mode;

  // A word in the compute stage is always waiting on the output next cycle.
  a_stage_delivers: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> out_valid)
    else $error("computed word did not reach the output queue");

  // Every accepted sample hands the next sample to the other channel.
  a_toggle_flips: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == OP_SAMPLE) |=> toggle != $past(toggle))
    else $error("channel toggle did not flip on a sample");

endmodule

`default_nettype wire

// File: tb/smoother_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels of the smoother, keeps its
// own copy of the filter, pickup and parameter state, and compares every
// result word against the oldest predicted word.
module smoother_checker
  import dasp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [OP_W-1:0]            op,
  input  logic [RAW_W-1:0]           raw_sample,
  input  logic [IDX_W-1:0]           param_index,
  input  logic signed [VALUE_W-1:0]  param_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       sample_channel,
  input  logic [SMOOTH_W-1:0]        smoothed_value,
  input  logic signed [VALUE_W-1:0]  active_value,
  input  logic [MODE_W-1:0]          pickup_mode,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         failures,
  output int                         words_in_flight
);

  localparam int SLOT_COUNT = 8;
  localparam int SHIFT      = 4;
  localparam int RAW_TOP    = 8191;
  localparam int REPORT_MAX = 10;

  // Shadow copy of the block's state and registers.
  logic                      chan_sel;
  logic [16:0]               filt_acc [2];
  logic [MODE_W-1:0]         mode_now;
  logic [SMOOTH_W-1:0]       pickup_ref;
  logic signed [VALUE_W-1:0] slot_table [SLOT_COUNT];
  logic [IDX_W-1:0]          live_slot;
  logic [CFG_W-1:0]          unlock_dist;

  // Predicted result words, oldest first.
  out_word_t awaited_words [$];

  task automatic flag(input string msg);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("[%0t] checker: %s", $realtime, msg);
    end
  endtask

  task automatic clear_model();
    chan_sel    = 1'b0;
    filt_acc[0] = '0;
    filt_acc[1] = '0;
    mode_now    = MODE_RESET;
    pickup_ref  = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      slot_table[k] = '0;
    end
    live_slot   = '0;
    unlock_dist = THRESHOLD_RESET;
  endtask

  // Applies one item to the shadow state and returns the word it must produce.
  function automatic out_word_t smooth_and_pickup(
    input logic [OP_W-1:0]           code,
    input logic [RAW_W-1:0]          raw,
    input logic [IDX_W-1:0]          idx,
    input logic signed [VALUE_W-1:0] val
  );
    out_word_t           w;
    int                  target;
    int                  acc;
    int                  delta;
    logic [SMOOTH_W-1:0] sm;
    logic [SMOOTH_W-1:0] gap;
    w = '0;
    case (code)
      OP_SAMPLE: begin
        // Inverted sample, one-pole step with a floor on the signed error.
        target = (RAW_TOP - int'(raw)) << SHIFT;
        acc    = int'(filt_acc[chan_sel]);
        delta  = target - acc;
        acc    = acc + (delta >>> SHIFT);
        if (acc < 0) begin
          acc = 0;
        end
        filt_acc[chan_sel] = acc[16:0];
        sm = acc[16:5];
        // Only channel one moves the pickup.
        if (chan_sel) begin
          case (mode_now)
            MODE_RESET: begin
              pickup_ref = sm;
              mode_now   = MODE_LOCKED;
            end
            MODE_LOCKED: begin
              gap = (sm >= pickup_ref) ? sm - pickup_ref : pickup_ref - sm;
              if (gap > unlock_dist) begin
                mode_now = MODE_TRACK;
              end
            end
            MODE_TRACK: begin
              slot_table[live_slot] = {4'b0000, sm};
            end
            default: ;
          endcase
        end
        w.ch       = chan_sel;
        w.smoothed = sm;
        chan_sel   = ~chan_sel;
      end
      OP_PARAM: begin
        slot_table[idx] = val;
      end
      OP_TRACK: begin
        mode_now = MODE_TRACK;
      end
      default: ;
    endcase
    w.active_value = slot_table[live_slot];
    w.mode         = mode_now;
    return w;
  endfunction

  // Result words are retired before new items are predicted; the block's
  // latency keeps an item from producing its word at its own edge.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      clear_model();
      awaited_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          flag($sformatf("result word with nothing awaited: ch=%0d sm=%0d val=%0d mode=%0d",
                         sample_channel, smoothed_value, active_value, pickup_mode));
        end else begin
          want = awaited_words.pop_front();
          if (sample_channel !== want.ch) begin
            flag($sformatf("sample_channel expected %0d got %0d", want.ch, sample_channel));
          end
          if (smoothed_value !== want.smoothed) begin
            flag($sformatf("smoothed_value expected %0d got %0d",
                           want.smoothed, smoothed_value));
          end
          if (active_value !== want.active_value) begin
            flag($sformatf("active_value expected %0d got %0d",
                           want.active_value, active_value));
          end
          if (pickup_mode !== want.mode) begin
            flag($sformatf("pickup_mode expected %0d got %0d", want.mode, pickup_mode));
          end
        end
      end
      // Register writes only arrive while nothing is in flight.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_PARAM: begin
            if (cfg_data[IDX_W-1:0] != live_slot) begin
              live_slot = cfg_data[IDX_W-1:0];
              mode_now  = MODE_RESET;
            end
          end
          REG_UNLOCK_THRESHOLD: begin
            unlock_dist = cfg_data;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        awaited_words.push_back(smooth_and_pickup(op, raw_sample, param_index, param_value));
      end
    end
    words_in_flight <= awaited_words.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dasp_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_WORDS = 300;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 6;
  localparam int RAW_TOP       = 8191;

  // Operation code the block leaves without effect.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           op          = OP_SAMPLE;
  logic [RAW_W-1:0]          raw_sample  = '0;
  logic [IDX_W-1:0]          param_index = '0;
  logic signed [VALUE_W-1:0] param_value = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic                      sample_channel;
  logic [SMOOTH_W-1:0]       smoothed_value;
  logic signed [VALUE_W-1:0] active_value;
  logic [MODE_W-1:0]         pickup_mode;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index   = REG_ACTIVE_PARAM;
  logic [CFG_W-1:0]          cfg_data    = '0;

  int failures;
  int words_in_flight;

  // Traffic knobs of the sender and the receiver.
  int         send_idle_pct = 32;
  int         recv_idle_pct = 76;
  bit         hold_req      = 1'b0;
  int         knob_level    = 4096;
  logic [2:0] last_slot     = '0;

  always #HALF_PERIOD clk = ~clk;

  dual_adc_smoother_with_param_pickup dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .raw_sample     (raw_sample),
    .param_index    (param_index),
    .param_value    (param_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample_channel (sample_channel),
    .smoothed_value (smoothed_value),
    .active_value   (active_value),
    .pickup_mode    (pickup_mode),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  smoother_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .raw_sample      (raw_sample),
    .param_index     (param_index),
    .param_value     (param_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sample_channel  (sample_channel),
    .smoothed_value  (smoothed_value),
    .active_value    (active_value),
    .pickup_mode     (pickup_mode),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .words_in_flight (words_in_flight)
  );

  // Offers one word after a random gap and returns at the edge that takes it.
  // Valid stays high into the next word when no gap follows.
  task automatic push_word(
    input logic [OP_W-1:0]    code,
    input logic [RAW_W-1:0]   raw,
    input logic [IDX_W-1:0]   idx,
    input logic [VALUE_W-1:0] val
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= code;
    raw_sample  <= raw;
    param_index <= idx;
    param_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every predicted word has been seen.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_in_flight != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Raw samples mostly follow a slowly turned knob, with jumps, rail values
  // and plain noise mixed in so the pickup both holds and unlocks.
  function automatic logic [RAW_W-1:0] pick_raw();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      knob_level = knob_level + int'($urandom_range(64)) - 32;
      if (knob_level < 0) knob_level = 0;
      if (knob_level > RAW_TOP) knob_level = RAW_TOP;
      return RAW_W'(knob_level);
    end else if (r < 70) begin
      knob_level = $urandom_range(RAW_TOP);
      return RAW_W'(knob_level);
    end else if (r < 80) begin
      return $urandom_range(1) ? RAW_W'(RAW_TOP) : '0;
    end
    return RAW_W'($urandom_range(RAW_TOP));
  endfunction

  task automatic push_random();
    int r;
    r = $urandom_range(99);
    if (r < 75) begin
      push_word(OP_SAMPLE, pick_raw(), IDX_W'($urandom()), VALUE_W'($urandom()));
    end else if (r < 88) begin
      push_word(OP_PARAM, RAW_W'($urandom()), IDX_W'($urandom()), VALUE_W'($urandom()));
    end else if (r < 94) begin
      push_word(OP_TRACK, RAW_W'($urandom()), IDX_W'($urandom()), VALUE_W'($urandom()));
    end else begin
      push_word(OP_NONE, RAW_W'($urandom()), IDX_W'($urandom()), VALUE_W'($urandom()));
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off when asked for.
  initial begin : result_sink
    int hold_left;
    bit hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [2:0]       slot;
    logic [CFG_W-1:0] thresh;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rails on both channels: channel one latches a zero reference, then its
    // value climbs past the default threshold and starts feeding slot zero.
    push_word(OP_SAMPLE, '0, '0, '0);
    push_word(OP_SAMPLE, RAW_W'(RAW_TOP), '0, '0);
    for (int k = 0; k < 5; k++) begin
      push_word(OP_SAMPLE, RAW_W'(RAW_TOP), '0, '0);
      push_word(OP_SAMPLE, '0, '0, '0);
    end
    // Table writes at the value extremes and alternating bit patterns.
    push_word(OP_PARAM, RAW_W'($urandom()), 3'd0, 16'h8000);
    push_word(OP_PARAM, RAW_W'($urandom()), 3'd7, 16'h7FFF);
    push_word(OP_PARAM, RAW_W'($urandom()), 3'd3, 16'h5555);
    push_word(OP_PARAM, RAW_W'($urandom()), 3'd4, 16'hAAAA);
    push_word(OP_NONE, RAW_W'($urandom()), IDX_W'($urandom()), VALUE_W'($urandom()));
    push_word(OP_TRACK, RAW_W'($urandom()), IDX_W'($urandom()), VALUE_W'($urandom()));

    // Rewriting the same slot must leave tracking alone.
    wait_idle();
    write_reg(REG_ACTIVE_PARAM, 12'd0);
    push_word(OP_SAMPLE, 13'd4096, '0, '0);
    push_word(OP_SAMPLE, 13'd100, '0, '0);
    // Moving to another slot puts the pickup back to its reset state.
    wait_idle();
    write_reg(REG_ACTIVE_PARAM, 12'd7);
    push_word(OP_SAMPLE, 13'd8000, '0, '0);
    push_word(OP_SAMPLE, 13'd2000, '0, '0);

    // Random segments, each with its own register setting; each pair of segments has its own traffic shape.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0: begin
          slot   = 3'd7;
          thresh = 12'd4095;
        end
        1: begin
          slot   = 3'd0;
          thresh = 12'd0;
        end
        3: begin
          slot   = last_slot;
          thresh = CFG_W'($urandom_range(31));
        end
        4: begin
          slot   = 3'($urandom_range(7));
          thresh = THRESHOLD_RESET;
        end
        default: begin
          slot   = 3'($urandom_range(7));
          thresh = CFG_W'($urandom());
        end
      endcase
      write_reg(REG_UNLOCK_THRESHOLD, thresh);
      write_reg(REG_ACTIVE_PARAM, {9'd0, slot});
      last_slot = slot;
      case (seg / 2)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct <= 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct <= 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      // The receiver holds off while the sender keeps offering at full rate.
      if (seg == 4) begin
        hold_req <= 1'b1;
      end
      repeat (SEGMENT_WORDS) push_random();
    end

    wait_idle();
    if (failures == 0 && words_in_flight == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : watchdog
    #5000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// File: sim.f
src/dasp_pkg.sv
src/dasp_filter.sv
src/dasp_param.sv
src/dasp_outbuf.sv
src/dual_adc_smoother_with_param_pickup.sv
tb/smoother_checker.sv
tb/tb_top.sv
